// ----- hw/rtl/tsp_pkg.sv -----
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types, constants and helpers for the transport stream packet parser.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int unsigned PACKET_BYTES = 188;
  localparam int unsigned POS_W        = 8;

  localparam logic [7:0] SYNC_BYTE  = 8'h47;
  localparam logic [7:0] STUFF_BYTE = 8'hFF;
  localparam logic [8:0] PCR_SCALE  = 9'd300;

  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(PACKET_BYTES - 1);
  localparam logic [7:0]       ALEN_MAX  = 8'(PACKET_BYTES - 5);
  localparam logic [8:0]       BODY_LEN  = 9'(PACKET_BYTES - 4);

  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_SYNC_LOST = 3'd1;
  localparam logic [2:0] ERR_TRANSPORT = 3'd2;
  localparam logic [2:0] ERR_ADAPT_LEN = 3'd3;
  localparam logic [2:0] ERR_PRIV_LEN  = 3'd4;
  localparam logic [2:0] ERR_EXT_LEN   = 3'd5;
  localparam logic [2:0] ERR_STUFFING  = 3'd6;

  typedef enum logic [1:0] {
    MODE_HUNT   = 2'd0,
    MODE_CAND   = 2'd1,
    MODE_LOCKED = 2'd2
  } sync_mode_t;

  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_ALEN      = 4'd1,
    PH_FLAGS     = 4'd2,
    PH_PCR       = 4'd3,
    PH_OPCR      = 4'd4,
    PH_SPLICE    = 4'd5,
    PH_PRIV_LEN  = 4'd6,
    PH_PRIV_SKIP = 4'd7,
    PH_EXT_LEN   = 4'd8,
    PH_EXT_SKIP  = 4'd9,
    PH_STUFF     = 4'd10,
    PH_PAYLOAD   = 4'd11,
    PH_SKIP      = 4'd12
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] sub;
    logic       overrun;
  } next_item_t;

  // Pick the next adaptation item after 'after'; left is the signed count of
  // adaptation bytes still to come after the byte just taken.
  function automatic next_item_t next_item(phase_t after, logic [7:0] fl,
                                           logic signed [9:0] left);
    next_item_t r;
    r.phase   = PH_SKIP;
    r.sub     = 8'd0;
    r.overrun = 1'b0;
    if (after < PH_PCR && fl[4]) begin
      r.phase = PH_PCR;
    end else if (after < PH_OPCR && fl[3]) begin
      r.phase = PH_OPCR;
    end else if (after < PH_SPLICE && fl[2]) begin
      r.phase = PH_SPLICE;
    end else if (after < PH_PRIV_LEN && fl[1]) begin
      r.phase = PH_PRIV_LEN;
    end else if (after < PH_EXT_LEN && fl[0]) begin
      r.phase = PH_EXT_LEN;
    end else if (left < 10'sd0) begin
      r.overrun = 1'b1;
    end else if (left == 10'sd0) begin
      r.phase = PH_PAYLOAD;
    end else begin
      r.sub   = left[7:0];
      r.phase = PH_STUFF;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/ts_packet_header_parser.sv -----
// ----------------------------------------------------------------------------
// ts_packet_header_parser
// Parses a transport stream taken one byte per transaction and returns one
// transaction of header, adaptation and clock reference fields per packet.
// ----------------------------------------------------------------------------
// The parser takes one byte of a transport stream in every cycle and keeps up
// with the stream at full rate: each byte is handled by one pass through the
// parse logic into the state registers, and the result of a packet is loaded
// into an output register at its last byte, or, for the first packet after a
// hunt, at the sync byte of the following packet that confirms lock. A lost
// sync byte while locked gives a result with the sync lost code at once. The
// clock reference product base*300+ext is computed in a register of its own
// from the collected bytes well before the end of the packet. A result is
// presented on the output in the cycle after the byte that produces it is
// taken. Input stalls only while a result still waits on the output and the
// byte on offer may produce one: the last byte of a packet, the byte after it
// while locked, or the byte after a candidate packet. A packet result can be
// followed at once by a sync lost result, so an output side that holds off
// the first of the two stalls the input for as long as it holds off.
module ts_packet_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_error_code,
  output logic [12:0] out_packet_id,
  output logic        out_start_indicator,
  output logic        out_transport_priority,
  output logic [1:0]  out_scramble_control,
  output logic [1:0]  out_adaptation_control,
  output logic [3:0]  out_continuity,
  output logic        out_discontinuity,
  output logic        out_access_point,
  output logic        out_clock_valid,
  output logic [41:0] out_clock_ref,
  output logic [7:0]  out_payload_length
);
  import tsp_pkg::*;

  sync_mode_t       mode_r, mode_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       alen_r, alen_nxt;
  logic [7:0]       sub_r, sub_nxt;
  logic [47:0]      cs_r, cs_nxt;
  logic [12:0]      pid_r, pid_nxt;
  logic             us_r, us_nxt;
  logic             pri_r, pri_nxt;
  logic [1:0]       sc_r, sc_nxt;
  logic [1:0]       ac_r, ac_nxt;
  logic [3:0]       cc_r, cc_nxt;
  logic [7:0]       af_r, af_nxt;
  logic             held_r, held_nxt;
  logic [2:0]       err_r, err_nxt;
  logic [41:0]      pcr_prod_r;

  logic             out_valid_r;
  logic [2:0]       out_err_r;
  logic [12:0]      out_pid_r;
  logic             out_us_r, out_pri_r;
  logic [1:0]       out_sc_r, out_ac_r;
  logic [3:0]       out_cc_r;
  logic             out_disc_r, out_ra_r, out_cv_r;
  logic [41:0]      out_ref_r;
  logic [7:0]       out_plen_r;

  logic             in_acc, may_emit;
  logic             emit, emit_lost, do_begin;

  // Values after the current byte is taken, before a new packet is begun.
  phase_t            t_phase;
  logic [7:0]        t_alen, t_sub, t_af;
  logic [47:0]       t_cs;
  logic [12:0]       t_pid;
  logic              t_us, t_pri;
  logic [1:0]        t_sc, t_ac;
  logic [3:0]        t_cc;
  logic [2:0]        t_err;
  logic              take;
  logic signed [9:0] left;
  logic [7:0]        sub_inc, sub_dec;
  next_item_t        ni;

  logic              ok, pcr_on;
  logic [8:0]        plen_full;

  assign may_emit = held_r || (pos_r == '0 && mode_r == MODE_LOCKED) || pos_r >= LAST_POS;
  assign in_ready = !out_valid_r || out_ready || !may_emit;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    take    = (held_r == 1'b0) && (mode_r == MODE_CAND || mode_r == MODE_LOCKED)
              && (pos_r != '0);
    left    = 10'(alen_r) - 10'(pos_r) + 10'sd4;
    sub_inc = sub_r + 8'd1;
    sub_dec = (sub_r != 8'd0) ? sub_r - 8'd1 : sub_r;
    ni      = next_item(phase_r, af_r, left);

    t_phase = phase_r;
    t_alen  = alen_r;
    t_sub   = sub_r;
    t_af    = af_r;
    t_cs    = cs_r;
    t_pid   = pid_r;
    t_us    = us_r;
    t_pri   = pri_r;
    t_sc    = sc_r;
    t_ac    = ac_r;
    t_cc    = cc_r;
    t_err   = err_r;

    if (take) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (pos_r == POS_W'(1)) begin
            if (in_stream_byte[7]) begin
              t_err = ERR_TRANSPORT;
            end
            t_pid[12:8] = in_stream_byte[4:0];
            t_us        = in_stream_byte[6];
            t_pri       = in_stream_byte[5];
          end else if (pos_r == POS_W'(2)) begin
            t_pid[7:0] = in_stream_byte;
          end else begin
            t_sc = in_stream_byte[7:6];
            t_ac = in_stream_byte[5:4];
            t_cc = in_stream_byte[3:0];
            if (err_r != ERR_OK) begin
              t_phase = PH_SKIP;
            end else if (in_stream_byte[5]) begin
              t_phase = PH_ALEN;
            end else begin
              t_phase = PH_PAYLOAD;
            end
          end
        end
        PH_ALEN: begin
          t_alen = in_stream_byte;
          if (in_stream_byte > ALEN_MAX) begin
            t_err   = ERR_ADAPT_LEN;
            t_phase = PH_SKIP;
          end else if (in_stream_byte == 8'd0) begin
            t_phase = PH_PAYLOAD;
          end else begin
            t_phase = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          t_af = in_stream_byte;
          ni   = next_item(PH_FLAGS, in_stream_byte, left);
          t_sub   = ni.sub;
          t_phase = ni.phase;
          if (ni.overrun) begin
            t_err = ERR_ADAPT_LEN;
          end
        end
        PH_PCR, PH_OPCR: begin
          if (phase_r == PH_PCR) begin
            t_cs = {cs_r[39:0], in_stream_byte};
          end
          t_sub = sub_inc;
          if (sub_inc >= 8'd6) begin
            t_sub   = ni.sub;
            t_phase = ni.phase;
            if (ni.overrun) begin
              t_err = ERR_ADAPT_LEN;
            end
          end
        end
        PH_SPLICE: begin
          t_sub   = ni.sub;
          t_phase = ni.phase;
          if (ni.overrun) begin
            t_err = ERR_ADAPT_LEN;
          end
        end
        PH_PRIV_LEN, PH_EXT_LEN: begin
          ni = next_item((phase_r == PH_PRIV_LEN) ? PH_PRIV_SKIP : PH_EXT_SKIP, af_r, left);
          if ($signed({2'b00, in_stream_byte}) > left) begin
            t_err   = (phase_r == PH_PRIV_LEN) ? ERR_PRIV_LEN : ERR_EXT_LEN;
            t_phase = PH_SKIP;
          end else if (in_stream_byte == 8'd0) begin
            t_sub   = ni.sub;
            t_phase = ni.phase;
            if (ni.overrun) begin
              t_err = ERR_ADAPT_LEN;
            end
          end else begin
            t_sub   = in_stream_byte;
            t_phase = (phase_r == PH_PRIV_LEN) ? PH_PRIV_SKIP : PH_EXT_SKIP;
          end
        end
        PH_PRIV_SKIP, PH_EXT_SKIP: begin
          t_sub = sub_dec;
          if (sub_dec == 8'd0) begin
            t_sub   = ni.sub;
            t_phase = ni.phase;
            if (ni.overrun) begin
              t_err = ERR_ADAPT_LEN;
            end
          end
        end
        PH_STUFF: begin
          if (in_stream_byte != STUFF_BYTE) begin
            t_err   = ERR_STUFFING;
            t_phase = PH_SKIP;
          end else begin
            t_sub = sub_dec;
            if (sub_dec == 8'd0) begin
              t_phase = PH_PAYLOAD;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    held_nxt  = held_r;
    emit      = 1'b0;
    emit_lost = 1'b0;
    do_begin  = 1'b0;
    if (held_r) begin
      held_nxt = 1'b0;
      if (in_stream_byte == SYNC_BYTE) begin
        emit     = 1'b1;
        mode_nxt = MODE_LOCKED;
        do_begin = 1'b1;
      end else begin
        mode_nxt = MODE_HUNT;
        pos_nxt  = '0;
      end
    end else if (mode_r != MODE_CAND && mode_r != MODE_LOCKED) begin
      mode_nxt = MODE_HUNT;
      pos_nxt  = '0;
      if (in_stream_byte == SYNC_BYTE) begin
        mode_nxt = MODE_CAND;
        do_begin = 1'b1;
      end
    end else if (pos_r == '0) begin
      if (in_stream_byte != SYNC_BYTE) begin
        emit_lost = (mode_r == MODE_LOCKED);
        mode_nxt  = MODE_HUNT;
      end else begin
        do_begin = 1'b1;
      end
    end else if (pos_r >= LAST_POS) begin
      pos_nxt = '0;
      if (mode_r == MODE_LOCKED) begin
        emit = 1'b1;
      end else begin
        held_nxt = 1'b1;
      end
    end else begin
      pos_nxt = pos_r + POS_W'(1);
    end

    phase_nxt = t_phase;
    alen_nxt  = t_alen;
    sub_nxt   = t_sub;
    cs_nxt    = t_cs;
    pid_nxt   = t_pid;
    us_nxt    = t_us;
    pri_nxt   = t_pri;
    sc_nxt    = t_sc;
    ac_nxt    = t_ac;
    cc_nxt    = t_cc;
    af_nxt    = t_af;
    err_nxt   = t_err;
    if (do_begin) begin
      phase_nxt = PH_HEADER;
      alen_nxt  = 8'd0;
      sub_nxt   = 8'd0;
      cs_nxt    = '0;
      pid_nxt   = '0;
      us_nxt    = 1'b0;
      pri_nxt   = 1'b0;
      sc_nxt    = '0;
      ac_nxt    = '0;
      cc_nxt    = '0;
      af_nxt    = '0;
      err_nxt   = ERR_OK;
      pos_nxt   = POS_W'(1);
    end
  end

  assign ok        = (t_err == ERR_OK);
  assign pcr_on    = ok && t_af[4];
  assign plen_full = BODY_LEN - (t_ac[1] ? 9'd1 + 9'(t_alen) : 9'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_HUNT;
      pos_r   <= '0;
      phase_r <= PH_HEADER;
      alen_r  <= '0;
      sub_r   <= '0;
      cs_r    <= '0;
      pid_r   <= '0;
      us_r    <= 1'b0;
      pri_r   <= 1'b0;
      sc_r    <= '0;
      ac_r    <= '0;
      cc_r    <= '0;
      af_r    <= '0;
      held_r  <= 1'b0;
      err_r   <= ERR_OK;
    end else if (in_acc) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      alen_r  <= alen_nxt;
      sub_r   <= sub_nxt;
      cs_r    <= cs_nxt;
      pid_r   <= pid_nxt;
      us_r    <= us_nxt;
      pri_r   <= pri_nxt;
      sc_r    <= sc_nxt;
      ac_r    <= ac_nxt;
      cc_r    <= cc_nxt;
      af_r    <= af_nxt;
      held_r  <= held_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pcr_prod_r <= 42'(cs_r[47:15]) * 42'(PCR_SCALE) + 42'(cs_r[8:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && (emit || emit_lost)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit_lost) begin
      out_err_r  <= ERR_SYNC_LOST;
      out_pid_r  <= '0;
      out_us_r   <= 1'b0;
      out_pri_r  <= 1'b0;
      out_sc_r   <= '0;
      out_ac_r   <= '0;
      out_cc_r   <= '0;
      out_disc_r <= 1'b0;
      out_ra_r   <= 1'b0;
      out_cv_r   <= 1'b0;
      out_ref_r  <= '0;
      out_plen_r <= '0;
    end else if (in_acc && emit) begin
      out_err_r  <= t_err;
      out_pid_r  <= t_pid;
      out_us_r   <= t_us;
      out_pri_r  <= t_pri;
      out_sc_r   <= t_sc;
      out_ac_r   <= t_ac;
      out_cc_r   <= t_cc;
      out_disc_r <= ok && t_af[7];
      out_ra_r   <= ok && t_af[6];
      out_cv_r   <= pcr_on;
      out_ref_r  <= pcr_on ? pcr_prod_r : '0;
      out_plen_r <= (ok && t_ac[0]) ? plen_full[7:0] : 8'd0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_error_code         = out_err_r;
  assign out_packet_id          = out_pid_r;
  assign out_start_indicator    = out_us_r;
  assign out_transport_priority = out_pri_r;
  assign out_scramble_control   = out_sc_r;
  assign out_adaptation_control = out_ac_r;
  assign out_continuity         = out_cc_r;
  assign out_discontinuity      = out_disc_r;
  assign out_access_point       = out_ra_r;
  assign out_clock_valid        = out_cv_r;
  assign out_clock_ref          = out_ref_r;
  assign out_payload_length     = out_plen_r;

  a_held_only_cand: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> mode_r == MODE_CAND)
    else $error("held result outside candidate mode");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("byte position beyond packet");

  a_held_clears: assert property (@(posedge clk) disable iff (!rst_n)
    held_r && in_acc |=> !held_r)
    else $error("held result not released");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready && in_acc |-> !(emit || emit_lost))
    else $error("pending result overwritten");

  a_lost_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r == ERR_SYNC_LOST |-> out_pid_r == '0 && !out_cv_r)
    else $error("sync lost result carries fields");

endmodule
